@@ design/wrcm_pkg.sv @@
// Shared widths, register indexes and reset values for the windowed RMS current meter.
package wrcm_pkg;

   // Sample and offset formats
   localparam int SAMPLE_BITS = 10;
   localparam int FRAC_BITS   = 16;
   localparam int OFFSET_W    = SAMPLE_BITS + FRAC_BITS;

   // Accumulation
   localparam int SUM_W    = 48;
   localparam int COUNT_W  = 16;
   localparam int SQ_SHIFT = 20;
   localparam int SQ_W     = 2 * OFFSET_W - SQ_SHIFT;

   // Serial units
   localparam int MUL_W      = OFFSET_W;
   localparam int MUL_CNT_W  = $clog2(MUL_W);
   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int RAD_W      = SUM_W + 4;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // Result formats
   localparam int RMS_W     = 18;
   localparam int PWM_W     = 10;
   localparam int SCALE_W   = 22;
   localparam int PWM_SHIFT = 24;
   localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};
   localparam logic [PWM_W-1:0] PWM_MAX = {PWM_W{1'b1}};

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SCALE_W;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KNEE_LOW      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KNEE_HIGH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_LOW     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_MID     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_HIGH    = 3'd5;

   // Reset values
   localparam logic [COUNT_W-1:0]  WINDOW_RESET     = 16'd5000;
   localparam logic [RMS_W-1:0]    KNEE_LOW_RESET   = 18'd4242;
   localparam logic [RMS_W-1:0]    KNEE_HIGH_RESET  = 18'd8483;
   localparam logic [SCALE_W-1:0]  SCALE_LOW_RESET  = 22'd924515;
   localparam logic [SCALE_W-1:0]  SCALE_MID_RESET  = 22'd1045138;
   localparam logic [SCALE_W-1:0]  SCALE_HIGH_RESET = 22'd1075801;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET     = 26'd51874365;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_W  = PWM_W + RMS_W + OFFSET_W;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

endpackage

@@ design/wrcm_serial_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module wrcm_serial_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wrcm_pkg::MUL_W-1:0]        mul_a,
   input  logic [wrcm_pkg::MUL_W-1:0]        mul_b,
   output logic                              done,
   output logic [2*wrcm_pkg::MUL_W-1:0]      product
);

   localparam logic [wrcm_pkg::MUL_CNT_W-1:0] LAST =
      wrcm_pkg::MUL_CNT_W'(wrcm_pkg::MUL_W - 1);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [wrcm_pkg::MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wrcm_pkg::MUL_W-1:0]       a_ff, a_in;
   logic [wrcm_pkg::MUL_W-1:0]       hi_ff, hi_in;
   logic [wrcm_pkg::MUL_W-1:0]       lo_ff, lo_in;
   logic [wrcm_pkg::MUL_W:0]         partial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      partial = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_a;
         hi_in   = '0;
         lo_in   = mul_b;
      end else if (busy_ff) begin
         // Add the partial product, then shift the pair right by one bit.
         hi_in  = partial[wrcm_pkg::MUL_W:1];
         lo_in  = {partial[0], lo_ff[wrcm_pkg::MUL_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

@@ design/wrcm_serial_div.sv @@
// Restoring divider, one quotient bit per cycle.
module wrcm_serial_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [wrcm_pkg::SUM_W-1:0]         dividend,
   input  logic [wrcm_pkg::COUNT_W-1:0]       divisor,
   output logic                               done,
   output logic [wrcm_pkg::SUM_W-1:0]         quotient
);

   localparam logic [wrcm_pkg::DIV_CNT_W-1:0] LAST =
      wrcm_pkg::DIV_CNT_W'(wrcm_pkg::SUM_W - 1);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [wrcm_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wrcm_pkg::SUM_W-1:0]       quo_ff, quo_in;
   logic [wrcm_pkg::COUNT_W-1:0]     rem_ff, rem_in;
   logic [wrcm_pkg::COUNT_W-1:0]     div_ff, div_in;
   logic [wrcm_pkg::COUNT_W:0]       rem_sh;
   logic [wrcm_pkg::COUNT_W:0]       rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      rem_sh  = {rem_ff, quo_ff[wrcm_pkg::SUM_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits shift in below.
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sub[wrcm_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[wrcm_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[wrcm_pkg::COUNT_W-1:0];
            quo_in = {quo_ff[wrcm_pkg::SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/wrcm_serial_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
module wrcm_serial_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wrcm_pkg::RAD_W-1:0]        radicand,
   output logic                              done,
   output logic [wrcm_pkg::ROOT_W-1:0]       root
);

   localparam logic [wrcm_pkg::ROOT_CNT_W-1:0] LAST =
      wrcm_pkg::ROOT_CNT_W'(wrcm_pkg::ROOT_W - 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [wrcm_pkg::ROOT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [wrcm_pkg::RAD_W-1:0]        rad_ff, rad_in;
   logic [wrcm_pkg::ROOT_W:0]         rem_ff, rem_in;
   logic [wrcm_pkg::ROOT_W-1:0]       root_ff, root_in;
   logic [wrcm_pkg::ROOT_W+2:0]       rem_sh;
   logic [wrcm_pkg::ROOT_W+2:0]       trial;
   logic [wrcm_pkg::ROOT_W+2:0]       rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, rad_ff[wrcm_pkg::RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // The remainder never exceeds twice the partial root, so it fits its register.
         if (rem_sh >= trial) begin
            rem_in  = rem_sub[wrcm_pkg::ROOT_W:0];
            root_in = {root_ff[wrcm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[wrcm_pkg::ROOT_W:0];
            root_in = {root_ff[wrcm_pkg::ROOT_W-2:0], 1'b0};
         end
         rad_in = {rad_ff[wrcm_pkg::RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ design/windowed_rms_current_meter.sv @@
// Top level of the windowed RMS current meter with DC offset tracking.
//
// Samples arrive as transactions on the req_ stream; req_tdata[9:0] holds one
// unsigned converter reading. Each sample moves the DC offset estimate toward
// itself and adds its squared deviation to the window sum. When the sample
// count reaches or passes window_length, one transaction leaves on the rsp_ stream with
// the PWM level, the RMS code in Q.8 and the current offset estimate.
// The csr_ port writes the six calibration and window registers; it is always
// ready and should only be used while the block is idle.
// A sample is taken only once the block is idle again: each one passes through the
// offset update, the bit-serial square of the deviation and the accumulation.
// A sample that closes a window then also passes through the serial divider, the
// serial square root and a second pass through the multiplier for the calibration
// before its result is presented.
// The result sits in an output register, so the block goes on taking samples
// while the receiver stalls; only a further window end waits for that register.
// Reset restores the register defaults and the offset estimate and clears the
// window sum, the sample count and any pending result.
module windowed_rms_current_meter #(
   parameter int OFFSET_SHIFT = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wrcm_pkg::REQ_DATA_W-1:0]     req_tdata,  // [9:0] sample
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wrcm_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [9:0] pwm_level,
                                                           // [27:10] rms_code_q8,
                                                           // [53:28] offset_estimate
   // Register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wrcm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wrcm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_OFFSET = 10'b00_0000_0010,
      S_MAG    = 10'b00_0000_0100,
      S_SQUARE = 10'b00_0000_1000,
      S_ACCUM  = 10'b00_0001_0000,
      S_CHECK  = 10'b00_0010_0000,
      S_DIVIDE = 10'b00_0100_0000,
      S_ROOT   = 10'b00_1000_0000,
      S_SCALE  = 10'b01_0000_0000,
      S_RESULT = 10'b10_0000_0000
   } state_type;

   localparam int OW = wrcm_pkg::OFFSET_W;
   localparam int MW = wrcm_pkg::MUL_W;

   state_type state_ff, state_in;

   // Configuration registers
   logic [wrcm_pkg::COUNT_W-1:0] window_length_ff;
   logic [wrcm_pkg::RMS_W-1:0]   knee_low_ff, knee_high_ff;
   logic [wrcm_pkg::SCALE_W-1:0] scale_low_ff, scale_mid_ff, scale_high_ff;

   // Measurement state
   logic [OW-1:0]                offset_ff, offset_in;
   logic [wrcm_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [wrcm_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [wrcm_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [wrcm_pkg::RMS_W-1:0]   rms_ff, rms_in;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [wrcm_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Datapath signals
   logic [OW-1:0]                target;
   logic signed [OW:0]           track_diff;
   logic signed [OW:0]           track_step;
   logic [OW:0]                  dev_diff;
   logic [OW-1:0]                dev_mag;
   logic [wrcm_pkg::SQ_W-1:0]    square;
   logic [wrcm_pkg::SUM_W:0]     sum_wide;
   logic [wrcm_pkg::RMS_W-1:0]   rms_sat;
   logic [wrcm_pkg::SCALE_W-1:0] scale_sel;
   logic [wrcm_pkg::PWM_W-1:0]   pwm;
   logic                         out_free;

   // Serial unit connections
   logic                         mul_start, mul_done;
   logic [MW-1:0]                mul_a, mul_b;
   logic [2*MW-1:0]              mul_product;
   logic                         div_start, div_done;
   logic [wrcm_pkg::COUNT_W-1:0] div_divisor;
   logic [wrcm_pkg::SUM_W-1:0]   div_quotient;
   logic                         sqrt_start, sqrt_done;
   logic [wrcm_pkg::ROOT_W-1:0]  sqrt_root;

   wrcm_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   wrcm_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   wrcm_serial_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({div_quotient, 4'b0000}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Offset tracking: an arithmetic right shift rounds the step toward minus infinity.
   assign target     = {sample_ff, {wrcm_pkg::FRAC_BITS{1'b0}}};
   assign track_diff = $signed({1'b0, target}) - $signed({1'b0, offset_ff});
   assign track_step = track_diff >>> OFFSET_SHIFT;

   // Deviation from the freshly updated offset.
   assign dev_diff = {1'b0, target} - {1'b0, offset_ff};
   assign dev_mag  = dev_diff[OW] ? OW'(-dev_diff) : dev_diff[OW-1:0];

   // The square is taken back from Q.32 to Q.12 by dropping the low bits.
   assign square   = mul_product[2*MW-1:wrcm_pkg::SQ_SHIFT];
   assign sum_wide = {1'b0, sum_ff} + {{(wrcm_pkg::SUM_W + 1 - wrcm_pkg::SQ_W){1'b0}}, square};

   // An empty count can only come from wraparound; the mean is then the sum itself.
   assign div_divisor = (count_ff == '0) ? wrcm_pkg::COUNT_W'(1) : count_ff;

   // The root is clamped to the result field before the segment is chosen.
   assign rms_sat = (sqrt_root > wrcm_pkg::ROOT_W'(wrcm_pkg::RMS_MAX)) ?
                    wrcm_pkg::RMS_MAX : sqrt_root[wrcm_pkg::RMS_W-1:0];

   always_comb begin
      if (rms_sat < knee_low_ff) begin
         scale_sel = scale_low_ff;
      end else if (rms_sat < knee_high_ff) begin
         scale_sel = scale_mid_ff;
      end else begin
         scale_sel = scale_high_ff;
      end
   end

   // Calibration product is Q.24 relative to the PWM code; anything above it saturates.
   assign pwm = (mul_product[2*MW-1:wrcm_pkg::PWM_SHIFT + wrcm_pkg::PWM_W] != '0) ?
                wrcm_pkg::PWM_MAX :
                mul_product[wrcm_pkg::PWM_SHIFT +: wrcm_pkg::PWM_W];

   // The multiplier is shared: the deviation square first, the calibration later.
   assign mul_start  = (state_ff == S_MAG) || ((state_ff == S_ROOT) && sqrt_done);
   assign mul_a      = (state_ff == S_MAG) ? dev_mag : MW'(rms_sat);
   assign mul_b      = (state_ff == S_MAG) ? dev_mag : MW'(scale_sel);
   assign div_start  = (state_ff == S_CHECK) && (count_ff >= window_length_ff);
   assign sqrt_start = (state_ff == S_DIVIDE) && div_done;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      sample_in    = sample_ff;
      rms_in       = rms_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[wrcm_pkg::SAMPLE_BITS-1:0];
               state_in  = S_OFFSET;
            end
         end
         S_OFFSET: begin
            offset_in = offset_ff + track_step[OW-1:0];
            state_in  = S_MAG;
         end
         S_MAG: begin
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            if (mul_done) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            sum_in   = sum_wide[wrcm_pkg::SUM_W] ? {wrcm_pkg::SUM_W{1'b1}} :
                       sum_wide[wrcm_pkg::SUM_W-1:0];
            count_in = count_ff + 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (div_start) begin
               // The divider holds its own copy, so the window restarts here.
               sum_in   = '0;
               count_in = '0;
               state_in = S_DIVIDE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (sqrt_done) begin
               rms_in   = rms_sat;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            if (mul_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = wrcm_pkg::RSP_DATA_W'({offset_ff, rms_ff, pwm});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         offset_ff    <= wrcm_pkg::OFFSET_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      rms_ff      <= rms_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Register file; writes past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= wrcm_pkg::WINDOW_RESET;
         knee_low_ff      <= wrcm_pkg::KNEE_LOW_RESET;
         knee_high_ff     <= wrcm_pkg::KNEE_HIGH_RESET;
         scale_low_ff     <= wrcm_pkg::SCALE_LOW_RESET;
         scale_mid_ff     <= wrcm_pkg::SCALE_MID_RESET;
         scale_high_ff    <= wrcm_pkg::SCALE_HIGH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            wrcm_pkg::REG_WINDOW_LENGTH: window_length_ff <= csr_wdata[wrcm_pkg::COUNT_W-1:0];
            wrcm_pkg::REG_KNEE_LOW:      knee_low_ff      <= csr_wdata[wrcm_pkg::RMS_W-1:0];
            wrcm_pkg::REG_KNEE_HIGH:     knee_high_ff     <= csr_wdata[wrcm_pkg::RMS_W-1:0];
            wrcm_pkg::REG_SCALE_LOW:     scale_low_ff     <= csr_wdata;
            wrcm_pkg::REG_SCALE_MID:     scale_mid_ff     <= csr_wdata;
            wrcm_pkg::REG_SCALE_HIGH:    scale_high_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

@@ design/wrcm_checker.sv @@
// Port-level checks for the windowed RMS current meter, bound to the top level.
module wrcm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [wrcm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result is pending right after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Each accepted sample keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted on consecutive cycles");

   // A new result is never loaded in the cycle right after a sample was taken.
   a_result_not_immediate: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared directly after a sample");

   // The configuration port never stalls.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind windowed_rms_current_meter wrcm_checker u_wrcm_checker (.*);

@@ tb/windowed_rms_current_meter_test.sv @@
// Self-checking testbench for the windowed RMS current meter with DC offset tracking.
`timescale 1ns / 1ps

module windowed_rms_current_meter_test;

   // The offset tracker's time constant; the block is built with the same value.
   localparam int TRACK_SHIFT = 10;
   // Long enough for a window end still in flight to run out and the block to go quiet.
   localparam int SETTLE_CYCLES = 150;
   localparam int unsigned CYCLE_LIMIT = 2_500_000;
   localparam int unsigned RANDOM_ITEMS = 1550;
   // Percentage of chances at which either side of the streams holds back.
   localparam int unsigned IDLE_PERCENT = 14;
   localparam longint unsigned SUM_CEILING = (64'd1 << wrcm_pkg::SUM_W) - 64'd1;
   // Indexes past the last register; writes to them must change nothing.
   localparam logic [wrcm_pkg::CSR_INDEX_W-1:0] SPARE_INDEX_A = 3'd6;
   localparam logic [wrcm_pkg::CSR_INDEX_W-1:0] SPARE_INDEX_B = 3'd7;

   // One result transaction; the first member sits in the highest bits, which
   // puts pwm_level in the lowest bits as on rsp_tdata.
   typedef struct packed {
      logic [wrcm_pkg::OFFSET_W-1:0] offset_estimate;
      logic [wrcm_pkg::RMS_W-1:0]    rms_code_q8;
      logic [wrcm_pkg::PWM_W-1:0]    pwm_level;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [wrcm_pkg::REQ_DATA_W-1:0]  req_tdata = '0;   // [9:0] sample
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [wrcm_pkg::RSP_DATA_W-1:0]  rsp_tdata;        // [9:0] pwm_level,
                                                       // [27:10] rms_code_q8,
                                                       // [53:28] offset_estimate
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [wrcm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [wrcm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Samples waiting to be driven, and readings the meter still owes us.
   logic [wrcm_pkg::SAMPLE_BITS-1:0] sample_backlog[$];
   reading_type                      pending_readings[$];

   // Our own copy of the meter: configuration registers and accumulation state.
   logic [wrcm_pkg::COUNT_W-1:0] cfg_window;
   logic [wrcm_pkg::RMS_W-1:0]   cfg_knee_low;
   logic [wrcm_pkg::RMS_W-1:0]   cfg_knee_high;
   logic [wrcm_pkg::SCALE_W-1:0] cfg_scale_low;
   logic [wrcm_pkg::SCALE_W-1:0] cfg_scale_mid;
   logic [wrcm_pkg::SCALE_W-1:0] cfg_scale_high;
   longint unsigned              meter_offset;
   longint unsigned              meter_sum;
   logic [wrcm_pkg::COUNT_W-1:0] meter_count;

   // While set, neither side of the streams holds back at all.
   logic        no_gaps = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   windowed_rms_current_meter #(
      .OFFSET_SHIFT(TRACK_SHIFT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input longint unsigned seen,
                                  input longint unsigned wanted);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, seen, wanted);
      mismatch_count++;
   endtask

   // Largest integer whose square does not exceed the radicand, found one
   // bit at a time from the top.
   function automatic longint unsigned floor_sqrt(input longint unsigned radicand);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand)
            root = trial;
      end
      return root;
   endfunction

   // Feeds one accepted sample through our copy of the meter. At a window end
   // the reading it owes is queued.
   task automatic advance_meter(input logic [wrcm_pkg::SAMPLE_BITS-1:0] smp);
      longint unsigned target;
      longint unsigned deviation;
      longint unsigned sq;
      longint unsigned mean;
      longint unsigned rms;
      longint unsigned scale;
      longint unsigned pwm;
      reading_type     reading;
      target = 64'(smp) << wrcm_pkg::FRAC_BITS;
      // The tracker step is an arithmetic shift: a move down rounds away from
      // zero, so the offset reaches a lower target instead of stopping short.
      if (target >= meter_offset)
         meter_offset = meter_offset + ((target - meter_offset) >> TRACK_SHIFT);
      else
         meter_offset = meter_offset -
                        ((meter_offset - target + (64'd1 << TRACK_SHIFT) - 64'd1) >>
                         TRACK_SHIFT);
      // The deviation is taken from the offset that this sample just moved.
      deviation = (target >= meter_offset) ? target - meter_offset : meter_offset - target;
      sq = (deviation * deviation) >> wrcm_pkg::SQ_SHIFT;
      meter_sum = (sq > SUM_CEILING - meter_sum) ? SUM_CEILING : meter_sum + sq;
      meter_count = meter_count + 1'b1;
      // A window length of zero ends every window at once, and a length
      // shortened below the count ends it on the next sample.
      if (meter_count < cfg_window)
         return;
      mean = (meter_count != 0) ? meter_sum / meter_count : meter_sum;
      rms = floor_sqrt(mean << 4);
      if (rms > wrcm_pkg::RMS_MAX)
         rms = wrcm_pkg::RMS_MAX;
      // The knees are tested low first, also when given in reverse order.
      if (rms < cfg_knee_low)
         scale = cfg_scale_low;
      else if (rms < cfg_knee_high)
         scale = cfg_scale_mid;
      else
         scale = cfg_scale_high;
      pwm = (rms * scale) >> wrcm_pkg::PWM_SHIFT;
      if (pwm > wrcm_pkg::PWM_MAX)
         pwm = wrcm_pkg::PWM_MAX;
      reading.pwm_level       = wrcm_pkg::PWM_W'(pwm);
      reading.rms_code_q8     = wrcm_pkg::RMS_W'(rms);
      reading.offset_estimate = wrcm_pkg::OFFSET_W'(meter_offset);
      pending_readings.push_back(reading);
      meter_sum   = 0;
      meter_count = '0;
   endtask

   // One register write. csr_valid stays high across back-to-back writes, and
   // the caller lowers it after the last one. Our copy of the register changes
   // at the edge where the transaction completes, with the same masking.
   task automatic write_setting(input logic [wrcm_pkg::CSR_INDEX_W-1:0] index,
                                input logic [wrcm_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         wrcm_pkg::REG_WINDOW_LENGTH: cfg_window     = data[wrcm_pkg::COUNT_W-1:0];
         wrcm_pkg::REG_KNEE_LOW:      cfg_knee_low   = data[wrcm_pkg::RMS_W-1:0];
         wrcm_pkg::REG_KNEE_HIGH:     cfg_knee_high  = data[wrcm_pkg::RMS_W-1:0];
         wrcm_pkg::REG_SCALE_LOW:     cfg_scale_low  = data[wrcm_pkg::SCALE_W-1:0];
         wrcm_pkg::REG_SCALE_MID:     cfg_scale_mid  = data[wrcm_pkg::SCALE_W-1:0];
         wrcm_pkg::REG_SCALE_HIGH:    cfg_scale_high = data[wrcm_pkg::SCALE_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until every sample has been taken and every reading has arrived,
   // then lets a window end that might still be in flight run out.
   task automatic wait_until_idle();
      while (sample_backlog.size() != 0 || req_tvalid || pending_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Knee values: mostly inside the range that real waveforms reach, with the
   // extremes and some values wider than the register.
   function automatic logic [wrcm_pkg::CSR_DATA_W-1:0] knee_value();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0: return '0;
         1: return wrcm_pkg::CSR_DATA_W'(wrcm_pkg::RMS_MAX);
         2: return wrcm_pkg::CSR_DATA_W'($urandom);
         default: return wrcm_pkg::CSR_DATA_W'($urandom_range(150000));
      endcase
   endfunction

   function automatic logic [wrcm_pkg::CSR_DATA_W-1:0] scale_value();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0: return '0;
         1: return {wrcm_pkg::CSR_DATA_W{1'b1}};
         default: return wrcm_pkg::CSR_DATA_W'($urandom);
      endcase
   endfunction

   // A new random setting for the next phase. The window length is always
   // written; it is kept short most of the time so that readings come often.
   // Its upper data bits are random and must be dropped by the block.
   task automatic shuffle_settings();
      int unsigned                  pick;
      logic [wrcm_pkg::COUNT_W-1:0] span;
      pick = $urandom_range(99);
      if (pick < 8)
         span = '0;
      else if (pick < 18)
         span = wrcm_pkg::COUNT_W'($urandom_range(300, 41));
      else if (pick < 22)
         span = {wrcm_pkg::COUNT_W{1'b1}};
      else
         span = wrcm_pkg::COUNT_W'($urandom_range(40, 1));
      write_setting(wrcm_pkg::REG_WINDOW_LENGTH, {6'($urandom), span});
      if ($urandom_range(1) == 1)
         write_setting(wrcm_pkg::REG_KNEE_LOW, knee_value());
      if ($urandom_range(1) == 1)
         write_setting(wrcm_pkg::REG_KNEE_HIGH, knee_value());
      if ($urandom_range(1) == 1)
         write_setting(wrcm_pkg::REG_SCALE_LOW, scale_value());
      if ($urandom_range(1) == 1)
         write_setting(wrcm_pkg::REG_SCALE_MID, scale_value());
      if ($urandom_range(1) == 1)
         write_setting(wrcm_pkg::REG_SCALE_HIGH, scale_value());
      if ($urandom_range(9) == 0)
         write_setting(($urandom_range(1) == 1) ? SPARE_INDEX_A : SPARE_INDEX_B,
                       wrcm_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Queues a run of samples. Most runs look like a sensed current: a
   // triangle wave with some noise around a DC level. The rest are uniform
   // noise, hops between the rails, or a nearly flat level.
   task automatic queue_waveform(input int unsigned n);
      int unsigned style;
      int unsigned dc;
      int unsigned amp;
      int unsigned period;
      int unsigned pos;
      int unsigned ramp;
      int          level;
      style  = $urandom_range(9);
      dc     = $urandom_range(923, 100);
      amp    = $urandom_range(511);
      period = $urandom_range(80, 4);
      for (int unsigned k = 0; k < n; k++) begin
         case (style) inside
            6, 9: level = int'($urandom_range(1023));
            7: level = ($urandom_range(1) == 1) ? 1023 : 0;
            8: level = int'(dc) + int'($urandom_range(4)) - 2;
            default: begin
               pos   = k % period;
               ramp  = (pos < period / 2) ? pos : period - pos;
               level = int'(dc) - int'(amp) + int'((4 * amp * ramp) / period) +
                       int'($urandom_range(16)) - 8;
            end
         endcase
         if (level < 0)
            level = 0;
         if (level > 1023)
            level = 1023;
         sample_backlog.push_back(wrcm_pkg::SAMPLE_BITS'(level));
      end
   endtask

   // Sample driver. The model sees a sample at the edge where its transaction
   // completes. Before presenting a new sample it sometimes holds off for a
   // stretch of cycles, so that gaps meet the block in every state of its work.
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            advance_meter(req_tdata[wrcm_pkg::SAMPLE_BITS-1:0]);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               if (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
                  gap_left   <= $urandom_range(40, 1);
                  req_tvalid <= 1'b0;
               end else begin
                  req_tvalid <= 1'b1;
                  req_tdata  <= {{(wrcm_pkg::REQ_DATA_W - wrcm_pkg::SAMPLE_BITS){1'b0}},
                                 sample_backlog.pop_front()};
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Each completed transaction is checked field by field
   // against the oldest owed reading. Ready drops in single cycles at random,
   // and now and then for a long stall after a reading, long enough for the
   // next window end to back up behind the output register.
   int unsigned stall_left = 0;

   always @(posedge clock) begin : result_monitor
      reading_type seen;
      reading_type wanted;
      int unsigned stall_next;
      logic        ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         stall_next = stall_left;
         if (rsp_tvalid && rsp_tready) begin
            seen = reading_type'(rsp_tdata[wrcm_pkg::RSP_RAW_W-1:0]);
            if (pending_readings.size() == 0) begin
               report_mismatch("reading with none owed", seen, 0);
            end else begin
               wanted = pending_readings.pop_front();
               if (seen.pwm_level != wanted.pwm_level)
                  report_mismatch("pwm_level", seen.pwm_level, wanted.pwm_level);
               if (seen.rms_code_q8 != wanted.rms_code_q8)
                  report_mismatch("rms_code_q8", seen.rms_code_q8, wanted.rms_code_q8);
               if (seen.offset_estimate != wanted.offset_estimate)
                  report_mismatch("offset_estimate", seen.offset_estimate,
                                  wanted.offset_estimate);
            end
            if (!no_gaps && $urandom_range(19) == 0)
               stall_next = $urandom_range(200, 1);
         end
         if (stall_next != 0) begin
            ready_next = 1'b0;
            stall_next = stall_next - 1;
         end else begin
            ready_next = no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
         end
         stall_left <= stall_next;
         rsp_tready <= ready_next;
      end
   end

   // Watchdog: a lost reading or a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] timeout: %0d samples waiting, %0d readings owed", $realtime,
                  sample_backlog.size(), pending_readings.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned random_items;
      int unsigned phase;
      int unsigned burst;

      // Our copy starts from the block's reset state.
      cfg_window     = wrcm_pkg::WINDOW_RESET;
      cfg_knee_low   = wrcm_pkg::KNEE_LOW_RESET;
      cfg_knee_high  = wrcm_pkg::KNEE_HIGH_RESET;
      cfg_scale_low  = wrcm_pkg::SCALE_LOW_RESET;
      cfg_scale_mid  = wrcm_pkg::SCALE_MID_RESET;
      cfg_scale_high = wrcm_pkg::SCALE_HIGH_RESET;
      meter_offset   = wrcm_pkg::OFFSET_RESET;
      meter_sum      = 0;
      meter_count    = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Rails and alternating bit patterns under the reset setting: the long
      // default window means no reading yet.
      sample_backlog.push_back(10'd0);
      sample_backlog.push_back(10'd1023);
      sample_backlog.push_back(10'h2AA);
      sample_backlog.push_back(10'h155);
      wait_until_idle();

      // Window shortened below the count: the next sample closes the window,
      // and the mean divides by the full count of five.
      write_setting(wrcm_pkg::REG_WINDOW_LENGTH, 22'd2);
      csr_valid <= 1'b0;
      sample_backlog.push_back(10'd0);
      wait_until_idle();

      // Zero window length gives a reading per sample; with both knees at the
      // far ends the middle segment at full scale drives the PWM into saturation.
      write_setting(wrcm_pkg::REG_WINDOW_LENGTH, 22'd0);
      write_setting(wrcm_pkg::REG_KNEE_LOW, 22'd0);
      write_setting(wrcm_pkg::REG_KNEE_HIGH, wrcm_pkg::CSR_DATA_W'(wrcm_pkg::RMS_MAX));
      write_setting(wrcm_pkg::REG_SCALE_MID, {wrcm_pkg::CSR_DATA_W{1'b1}});
      csr_valid <= 1'b0;
      sample_backlog.push_back(10'd1023);
      sample_backlog.push_back(10'd0);
      wait_until_idle();

      // Knees in reverse order (the high one masks down to zero): the low
      // segment still wins, here with a zero scale. Writes to the unused
      // indexes must leave every register alone.
      write_setting(wrcm_pkg::REG_KNEE_LOW, wrcm_pkg::CSR_DATA_W'(wrcm_pkg::RMS_MAX));
      write_setting(wrcm_pkg::REG_KNEE_HIGH, 22'h3C0000);
      write_setting(wrcm_pkg::REG_SCALE_LOW, 22'd0);
      write_setting(SPARE_INDEX_A, 22'd1);
      write_setting(SPARE_INDEX_B, {wrcm_pkg::CSR_DATA_W{1'b1}});
      csr_valid <= 1'b0;
      sample_backlog.push_back(10'd1023);
      sample_backlog.push_back(10'd512);
      wait_until_idle();

      // Both knees at zero select the high segment, at full scale.
      write_setting(wrcm_pkg::REG_KNEE_LOW, 22'd0);
      write_setting(wrcm_pkg::REG_KNEE_HIGH, 22'd0);
      write_setting(wrcm_pkg::REG_SCALE_HIGH, {wrcm_pkg::CSR_DATA_W{1'b1}});
      write_setting(wrcm_pkg::REG_WINDOW_LENGTH, 22'd1);
      csr_valid <= 1'b0;
      sample_backlog.push_back(10'd0);
      sample_backlog.push_back(10'd1023);
      sample_backlog.push_back(10'd300);
      wait_until_idle();

      // Longest window: a few samples gather, then a window of one closes it.
      write_setting(wrcm_pkg::REG_WINDOW_LENGTH, 22'h00FFFF);
      csr_valid <= 1'b0;
      sample_backlog.push_back(10'd200);
      sample_backlog.push_back(10'd900);
      sample_backlog.push_back(10'd17);
      wait_until_idle();
      write_setting(wrcm_pkg::REG_WINDOW_LENGTH, 22'd1);
      csr_valid <= 1'b0;
      sample_backlog.push_back(10'd640);
      wait_until_idle();

      // Random phases, each with a fresh setting. One longer phase runs with
      // no idling on either side at all.
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         shuffle_settings();
         no_gaps <= (phase == 4);
         burst = (phase == 4) ? 200 : $urandom_range(90, 20);
         queue_waveform(burst);
         random_items += burst;
         phase++;
         wait_until_idle();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ windowed_rms_current_meter.f @@
design/wrcm_pkg.sv
design/wrcm_serial_mul.sv
design/wrcm_serial_div.sv
design/wrcm_serial_sqrt.sv
design/windowed_rms_current_meter.sv
design/wrcm_checker.sv
tb/windowed_rms_current_meter_test.sv
